/* design/sgm_pkg.sv */
// Shared types and constants for the Sobel gradient magnitude block.
// Holds the field widths, register indexes and stream codes.
// Depends on nothing; the top level refers to it by scoped names.
package sgm_pkg;

    localparam int PIXEL_W     = 8;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int ROW_COUNT_W = 16;

    // Gradient sums fit in 10 bits (4 * 255), their squares in 20 bits,
    // and the sum of both squares in 21 bits.
    localparam int GRAD_W = 10;
    localparam int SQ_W   = 20;
    localparam int SUM_W  = 21;

    typedef logic [PIXEL_W-1:0] sample_t;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_LENGTH = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT  = 4'd1;

    // Kind of input transaction, carried on tuser.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam int MIN_DIM          = 3;
    localparam int RESET_ROW_LENGTH = 640;
    localparam int RESET_ROW_COUNT  = 480;

    localparam sample_t MAG_MAX = 8'd255;

endpackage

/* design/sobel_gradient_magnitude.sv */
// Sobel 3x3 gradient magnitude over a raster stream of 8-bit samples.
// Two line stores in synchronous memories, a 3x3 window and a bit-serial
// square root unit. Depends on sgm_pkg.
//
// Usage: samples enter on the slave stream (s_tdata = pixel, s_tuser = op,
// where op 0 is a sample and op 1 is a flush tick). Results leave on the
// master stream (m_tdata = magnitude, m_tlast = last result of a frame).
// A result lags its input by one row plus one sample; after the last sample
// of a frame, row_length + 1 flush transactions drain the pending results.
// A new frame may also follow directly, each of its samples pushing out one
// pending result of the previous frame.
//
// Sequence: one item is handled at a time. A sample that yields no result
// passes the memory read, then the window shift and write back. A border
// result adds the output state; a saturated result adds the two squaring
// states and the output state, and an interior result also the eight-step
// square root before the output state. An ignored flush is only taken.
//
// Reset clears the window, the position counters and the pending count and
// loads the default geometry (640 x 480); the line stores are not cleared.
// The output register holds a result while m_tready is low; the block only
// waits when a new result is ready to be loaded behind it.
// Writing either register restarts the frame; any write holds off the input.
module sobel_gradient_magnitude #(
    parameter int MAX_LINE = 2048
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Input stream.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] pixel
    input  logic                               s_tuser,   // [0] op
    // Result stream.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,   // [7:0] magnitude
    output logic                               m_tlast,   // frame_end
    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sgm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sgm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Column index width and width of a length value (up to MAX_LINE + 1).
    localparam int CW = $clog2(MAX_LINE);
    localparam int LW = $clog2(MAX_LINE + 2);
    localparam int RW = sgm_pkg::ROW_COUNT_W;

    localparam int unsigned RESET_LEN =
        (sgm_pkg::RESET_ROW_LENGTH > MAX_LINE) ? MAX_LINE : sgm_pkg::RESET_ROW_LENGTH;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_SQX,
        S_SQY,
        S_ROOT,
        S_OUT
    } state_t;

    state_t state_reg;

    // Geometry, kept with the derived values that the counters compare with.
    logic [LW-1:0] len_reg;
    logic [LW-1:0] len_p1_reg;
    logic [CW-1:0] len_m1_reg;
    logic [RW-1:0] rows_m1_reg;

    // Positions of the next input and the next result, and the number of
    // results still owed.
    logic [CW-1:0] in_col_reg;
    logic [RW-1:0] in_row_reg;
    logic [CW-1:0] out_col_reg;
    logic [RW-1:0] out_row_reg;
    logic [LW-1:0] pend_reg;

    sgm_pkg::sample_t win_reg [3][3];

    // Line stores and their registered read data.
    sgm_pkg::sample_t line_upper_mem  [MAX_LINE];
    sgm_pkg::sample_t line_middle_mem [MAX_LINE];
    sgm_pkg::sample_t line_upper_rd_reg;
    sgm_pkg::sample_t line_middle_rd_reg;

    // Item in flight.
    logic [CW-1:0]    addr_reg;
    sgm_pkg::sample_t bot_reg;
    logic             is_sample_reg;
    logic             emit_reg;
    logic             border_reg;
    logic             frame_end_reg;

    // Arithmetic pipeline.
    logic [sgm_pkg::GRAD_W-1:0] gx_reg;
    logic [sgm_pkg::GRAD_W-1:0] gy_reg;
    logic [sgm_pkg::SQ_W-1:0]   sq_reg;
    logic [15:0]                rad_reg;
    logic [9:0]                 rem_reg;
    sgm_pkg::sample_t           root_reg;
    logic [2:0]                 step_reg;
    sgm_pkg::sample_t           mag_reg;

    // Output register.
    logic             m_tvalid_reg;
    sgm_pkg::sample_t m_tdata_reg;
    logic             m_tlast_reg;

    // Decision logic for the transaction offered on the input.
    logic          take;
    logic          at_start;
    logic          is_flush;
    logic          drop;
    logic          flush_live;
    logic          emit_sample;
    logic          rd_en;
    logic [LW-1:0] pend_eff;
    logic [LW-1:0] drain_col;
    logic [CW-1:0] rd_addr;
    logic          out_border;
    logic          out_last;

    logic [CW-1:0] in_col_next;
    logic [RW-1:0] in_row_next;
    logic [CW-1:0] out_col_next;
    logic [RW-1:0] out_row_next;

    // Gradient of the window after the shift.
    logic [sgm_pkg::GRAD_W-1:0] sum_right;
    logic [sgm_pkg::GRAD_W-1:0] sum_left;
    logic [sgm_pkg::GRAD_W-1:0] sum_bottom;
    logic [sgm_pkg::GRAD_W-1:0] sum_top;
    logic [sgm_pkg::GRAD_W-1:0] gx_abs;
    logic [sgm_pkg::GRAD_W-1:0] gy_abs;

    logic [sgm_pkg::SQ_W-1:0]   gx_sq;
    logic [sgm_pkg::SQ_W-1:0]   gy_sq;
    logic [sgm_pkg::SUM_W-1:0]  sum_sq;

    logic [11:0]      rem_shift;
    logic [11:0]      root_trial;
    logic             root_fits;
    logic [11:0]      rem_new;
    sgm_pkg::sample_t root_new;

    // Configuration decode.
    logic        cfg_take;
    int unsigned cfg_len;
    int unsigned cfg_rows;

    // A configuration write has the cycle to itself, so the counters never
    // see a new item and a restart at the same edge.
    assign s_tready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;

    always_comb
    begin
        take       = s_tvalid && s_tready;
        at_start   = (in_col_reg == '0) && (in_row_reg == '0);
        is_flush   = (s_tuser == sgm_pkg::OP_FLUSH);
        // A sample at the start of a frame after a partial drain discards the
        // results still owed to the previous frame.
        drop       = !is_flush && at_start && (pend_reg != '0) && (pend_reg <= len_reg);
        pend_eff   = drop ? '0 : pend_reg;
        emit_sample = (pend_eff == len_p1_reg);
        // A flush only counts at a frame boundary with results still owed.
        flush_live = is_flush && at_start && (pend_reg != '0);
        // While draining, the column that feeds the window walks forward from
        // the start of the last row.
        drain_col  = len_p1_reg - pend_reg;
        if (is_flush)
        begin
            rd_addr = (drain_col < len_reg) ? CW'(drain_col) : '0;
        end
        else
        begin
            rd_addr = in_col_reg;
        end
        rd_en = take && (!is_flush || flush_live);

        out_border = (out_row_reg == '0) || (out_row_reg == rows_m1_reg)
                  || (out_col_reg == '0) || (out_col_reg == len_m1_reg);
        out_last   = (out_row_reg == rows_m1_reg) && (out_col_reg == len_m1_reg);

        if (in_col_reg == len_m1_reg)
        begin
            in_col_next = '0;
            in_row_next = (in_row_reg == rows_m1_reg) ? '0 : in_row_reg + 1'b1;
        end
        else
        begin
            in_col_next = in_col_reg + 1'b1;
            in_row_next = in_row_reg;
        end

        if (out_col_reg == len_m1_reg)
        begin
            out_col_next = '0;
            out_row_next = (out_row_reg == rows_m1_reg) ? '0 : out_row_reg + 1'b1;
        end
        else
        begin
            out_col_next = out_col_reg + 1'b1;
            out_row_next = out_row_reg;
        end
    end

    // The window after the shift holds the old middle and right columns on
    // the left and the memory read data plus the new sample on the right.
    always_comb
    begin
        sum_right  = 10'(line_upper_rd_reg) + {1'b0, line_middle_rd_reg, 1'b0}
                   + 10'(bot_reg);
        sum_left   = 10'(win_reg[0][1]) + {1'b0, win_reg[1][1], 1'b0}
                   + 10'(win_reg[2][1]);
        sum_bottom = 10'(win_reg[2][1]) + {1'b0, win_reg[2][2], 1'b0}
                   + 10'(bot_reg);
        sum_top    = 10'(win_reg[0][1]) + {1'b0, win_reg[0][2], 1'b0}
                   + 10'(line_upper_rd_reg);
        gx_abs = (sum_right >= sum_left) ? sum_right - sum_left : sum_left - sum_right;
        gy_abs = (sum_bottom >= sum_top) ? sum_bottom - sum_top : sum_top - sum_bottom;

        gx_sq  = 20'(gx_reg) * 20'(gx_reg);
        gy_sq  = 20'(gy_reg) * 20'(gy_reg);
        sum_sq = 21'(sq_reg) + 21'(gy_sq);

        // One step of the digit-by-digit square root.
        rem_shift  = {rem_reg, rad_reg[15:14]};
        root_trial = 12'({root_reg, 2'b01});
        root_fits  = (rem_shift >= root_trial);
        rem_new    = root_fits ? rem_shift - root_trial : rem_shift;
        root_new   = {root_reg[6:0], root_fits};
    end

    always_comb
    begin
        cfg_take = cfg_valid && cfg_ready;
        cfg_len  = 32'(cfg_data[11:0]);
        if (cfg_len < sgm_pkg::MIN_DIM)
        begin
            cfg_len = sgm_pkg::MIN_DIM;
        end
        else if (cfg_len > MAX_LINE)
        begin
            cfg_len = MAX_LINE;
        end
        cfg_rows = 32'(cfg_data[RW-1:0]);
        if (cfg_rows < sgm_pkg::MIN_DIM)
        begin
            cfg_rows = sgm_pkg::MIN_DIM;
        end
    end

    // Line stores: read when a sample or live flush is taken, written back
    // for samples in the following update state; reads never overlap writes.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            line_upper_rd_reg  <= line_upper_mem[rd_addr];
            line_middle_rd_reg <= line_middle_mem[rd_addr];
        end
        if (state_reg == S_UPD && is_sample_reg)
        begin
            line_upper_mem[addr_reg]  <= line_middle_rd_reg;
            line_middle_mem[addr_reg] <= bot_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= LW'(RESET_LEN);
            len_p1_reg    <= LW'(RESET_LEN + 1);
            len_m1_reg    <= CW'(RESET_LEN - 1);
            rows_m1_reg   <= RW'(sgm_pkg::RESET_ROW_COUNT - 1);
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            pend_reg      <= '0;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
            addr_reg      <= '0;
            bot_reg       <= '0;
            is_sample_reg <= 1'b0;
            emit_reg      <= 1'b0;
            border_reg    <= 1'b0;
            frame_end_reg <= 1'b0;
            gx_reg        <= '0;
            gy_reg        <= '0;
            sq_reg        <= '0;
            rad_reg       <= '0;
            rem_reg       <= '0;
            root_reg      <= '0;
            step_reg      <= '0;
            mag_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
            m_tlast_reg   <= 1'b0;
        end
        else
        begin
            // In the output state the register is reloaded below instead.
            if (m_tvalid_reg && m_tready && state_reg != S_OUT)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (take)
                    begin
                        addr_reg      <= rd_addr;
                        border_reg    <= out_border;
                        frame_end_reg <= out_last;
                        if (is_flush)
                        begin
                            if (flush_live)
                            begin
                                bot_reg       <= '0;
                                is_sample_reg <= 1'b0;
                                emit_reg      <= 1'b1;
                                pend_reg      <= pend_reg - 1'b1;
                                out_col_reg   <= out_col_next;
                                out_row_reg   <= out_row_next;
                                state_reg     <= S_UPD;
                            end
                        end
                        else
                        begin
                            bot_reg       <= s_tdata;
                            is_sample_reg <= 1'b1;
                            emit_reg      <= emit_sample;
                            in_col_reg    <= in_col_next;
                            in_row_reg    <= in_row_next;
                            if (emit_sample)
                            begin
                                out_col_reg <= out_col_next;
                                out_row_reg <= out_row_next;
                            end
                            else
                            begin
                                pend_reg <= pend_eff + 1'b1;
                                if (drop)
                                begin
                                    out_col_reg <= '0;
                                    out_row_reg <= '0;
                                end
                            end
                            state_reg <= S_UPD;
                        end
                    end
                end

                S_UPD:
                begin
                    for (int r = 0; r < 3; r++)
                    begin
                        win_reg[r][0] <= win_reg[r][1];
                        win_reg[r][1] <= win_reg[r][2];
                    end
                    win_reg[0][2] <= line_upper_rd_reg;
                    win_reg[1][2] <= line_middle_rd_reg;
                    win_reg[2][2] <= bot_reg;
                    gx_reg <= gx_abs;
                    gy_reg <= gy_abs;
                    if (!emit_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (border_reg)
                    begin
                        // Border positions pass the center sample through.
                        mag_reg   <= win_reg[1][2];
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_SQX;
                    end
                end

                S_SQX:
                begin
                    sq_reg    <= gx_sq;
                    state_reg <= S_SQY;
                end

                S_SQY:
                begin
                    rad_reg  <= sum_sq[15:0];
                    rem_reg  <= '0;
                    root_reg <= '0;
                    step_reg <= 3'd7;
                    if (sum_sq[sgm_pkg::SUM_W-1:16] != '0)
                    begin
                        mag_reg   <= sgm_pkg::MAG_MAX;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_ROOT;
                    end
                end

                S_ROOT:
                begin
                    rad_reg  <= {rad_reg[13:0], 2'b00};
                    rem_reg  <= 10'(rem_new);
                    root_reg <= root_new;
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == '0)
                    begin
                        mag_reg   <= root_new;
                        state_reg <= S_OUT;
                    end
                end

                S_OUT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= mag_reg;
                        m_tlast_reg  <= frame_end_reg;
                        state_reg    <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // A write to either register restarts the frame and drops owed results.
            if (cfg_take)
            begin
                unique case (cfg_index)
                    sgm_pkg::REG_ROW_LENGTH:
                    begin
                        len_reg     <= LW'(cfg_len);
                        len_p1_reg  <= LW'(cfg_len + 1);
                        len_m1_reg  <= CW'(cfg_len - 1);
                        in_col_reg  <= '0;
                        in_row_reg  <= '0;
                        out_col_reg <= '0;
                        out_row_reg <= '0;
                        pend_reg    <= '0;
                    end
                    sgm_pkg::REG_ROW_COUNT:
                    begin
                        rows_m1_reg <= RW'(cfg_rows - 1);
                        in_col_reg  <= '0;
                        in_row_reg  <= '0;
                        out_col_reg <= '0;
                        out_row_reg <= '0;
                        pend_reg    <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule
